// File: rtl/awa_pkg.sv
// Shared widths, types and the arctangent table of the wheel-angle unit.
package awa_pkg;

    localparam int unsigned LenW     = 16;  // Q12.4 lengths
    localparam int unsigned AngW     = 16;  // Q8.8 angles
    localparam int unsigned CfgIdxW  = 1;
    localparam int unsigned CordW    = 30;  // CORDIC x/y, signed
    localparam int unsigned ZW       = 25;  // accumulated angle, signed Q.16
    localparam int unsigned AccW     = 27;  // 90 deg +/- z
    localparam int unsigned TabN     = 24;
    localparam int unsigned TabW     = 22;
    localparam int unsigned InScaleSh = 8;  // inputs times 256
    localparam int unsigned DefSteps = 16;

    localparam logic [CfgIdxW-1:0] RegTrackWidth = 1'd0;
    localparam logic [CfgIdxW-1:0] RegWheelbase  = 1'd1;
    localparam logic [LenW-1:0]    TrackReset    = 16'd0;
    localparam logic [LenW-1:0]    BaseReset     = 16'd16;

    localparam logic signed [AccW-1:0] Deg90Q16  = 27'sd5898240;
    localparam logic signed [AccW-1:0] Deg180Q16 = 27'sd11796480;
    localparam logic signed [AccW-1:0] HalfLsb   = 27'sd128;

    // atan(2^-i) in degrees, Q.16, rounded to nearest
    localparam logic [TabW-1:0] AtanTab [TabN] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
        22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
        22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
    };

    typedef struct packed {
        logic signed [CordW-1:0] x_l;
        logic signed [CordW-1:0] y_l;
        logic signed [ZW-1:0]    z_l;
        logic signed [CordW-1:0] x_r;
        logic signed [CordW-1:0] y_r;
        logic signed [ZW-1:0]    z_r;
        logic                    dir;
    } t_vec;

endpackage

// File: rtl/awa_entry.sv
// Input stage: holds the register file and forms the starting CORDIC vectors.
module awa_entry (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [awa_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [awa_pkg::LenW-1:0]     i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [awa_pkg::LenW-1:0]     i_radius,
    input  logic                         i_dir,
    output logic                         o_valid,
    input  logic                         i_ready,
    output awa_pkg::t_vec                o_data
);
    import awa_pkg::*;

    logic [LenW-1:0] r_track;
    logic [LenW-1:0] r_base;
    logic            r_valid;
    t_vec            r_data;
    t_vec            n_data;
    logic signed [CordW-1:0] s_r2, s_w;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track <= TrackReset;
            r_base  <= BaseReset;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                RegTrackWidth: r_track <= i_cfg_data;
                RegWheelbase:  r_base  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        s_r2 = CordW'({i_radius, 1'b0});
        s_w  = CordW'(r_track);
        n_data     = '0;
        n_data.x_l = CordW'({r_base, 1'b0}) <<< InScaleSh;
        n_data.x_r = n_data.x_l;
        n_data.y_l = (s_r2 + s_w) <<< InScaleSh;
        n_data.y_r = (s_r2 - s_w) <<< InScaleSh;
        n_data.dir = i_dir;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

// File: rtl/awa_cell.sv
// One vectoring CORDIC step for both wheels, registered.
module awa_cell #(
    parameter int unsigned STEP = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  awa_pkg::t_vec i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output awa_pkg::t_vec o_data
);
    import awa_pkg::*;

    localparam logic signed [ZW-1:0] Ang = ZW'(AtanTab[STEP]);

    logic r_valid;
    t_vec r_data;
    t_vec n_data;
    logic signed [CordW-1:0] xs_l, ys_l, xs_r, ys_r;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        xs_l = i_data.x_l >>> STEP;
        ys_l = i_data.y_l >>> STEP;
        xs_r = i_data.x_r >>> STEP;
        ys_r = i_data.y_r >>> STEP;
        n_data = i_data;
        // rotate toward the x axis; sign of y picks the direction
        if (!i_data.y_l[CordW-1]) begin
            n_data.x_l = i_data.x_l + ys_l;
            n_data.y_l = i_data.y_l - xs_l;
            n_data.z_l = i_data.z_l + Ang;
        end else begin
            n_data.x_l = i_data.x_l - ys_l;
            n_data.y_l = i_data.y_l + xs_l;
            n_data.z_l = i_data.z_l - Ang;
        end
        if (!i_data.y_r[CordW-1]) begin
            n_data.x_r = i_data.x_r + ys_r;
            n_data.y_r = i_data.y_r - xs_r;
            n_data.z_r = i_data.z_r + Ang;
        end else begin
            n_data.x_r = i_data.x_r - ys_r;
            n_data.y_r = i_data.y_r + xs_r;
            n_data.z_r = i_data.z_r - Ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

// File: rtl/awa_finish.sv
// Angle finish: apply heading, clamp, round, then take the larger angle.
module awa_finish (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  awa_pkg::t_vec             i_data,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [awa_pkg::AngW-1:0]  o_left,
    output logic [awa_pkg::AngW-1:0]  o_right,
    output logic [awa_pkg::AngW-1:0]  o_larger
);
    import awa_pkg::*;

    function automatic logic [AngW-1:0] finish_angle(input logic signed [ZW-1:0] z,
                                                      input logic dir);
        logic signed [AccW-1:0] a;
        logic signed [AccW-1:0] r;
        a = dir ? (Deg90Q16 - AccW'(z)) : (Deg90Q16 + AccW'(z));
        if (a < 0) begin
            a = '0;
        end else if (a > Deg180Q16) begin
            a = Deg180Q16;
        end
        r = a + HalfLsb;
        return r[AngW+7:8];
    endfunction

    logic            r_a_valid, r_o_valid;
    logic [AngW-1:0] r_a_left, r_a_right;
    logic [AngW-1:0] r_left, r_right, r_larger;
    logic            s_o_ready;

    assign s_o_ready = !r_o_valid || i_ready;
    assign o_ready   = !r_a_valid || s_o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_a_valid <= i_valid;
            end
            if (s_o_ready) begin
                r_o_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_a_left  <= finish_angle(i_data.z_l, i_data.dir);
            r_a_right <= finish_angle(i_data.z_r, i_data.dir);
        end
        if (s_o_ready && r_a_valid) begin
            r_left   <= r_a_left;
            r_right  <= r_a_right;
            r_larger <= (r_a_left > r_a_right) ? r_a_left : r_a_right;
        end
    end

    assign o_valid  = r_o_valid;
    assign o_left   = r_left;
    assign o_right  = r_right;
    assign o_larger = r_larger;
endmodule

// File: rtl/ackermann_wheel_angles.sv
// Ackermann wheel angles: CORDIC cell chain from turn radius to both wheel angles.
// Word path: entry register, one per CORDIC cell, finish angle and output registers.
// One word per cycle unless the output stalls; each cell of the chain holds one word.
// Stalls fill bubbles: a stage takes a word whenever it is empty or draining.
// Reset (synchronous, active low) empties the pipe, track width 0, wheelbase 16.
module ackermann_wheel_angles #(
    parameter int unsigned CORDIC_STEPS = awa_pkg::DefSteps
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [awa_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [awa_pkg::LenW-1:0]     i_cfg_data,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [15:0]                  i_s_axis_tdata,  // [15:0] turn_radius
    input  logic                         i_s_axis_tuser,  // [0] heading_positive
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    output logic [47:0]                  o_m_axis_tdata   // [15:0] left_angle,
                                                          // [31:16] right_angle,
                                                          // [47:32] larger_angle
);
    import awa_pkg::*;

    logic            v_valid [CORDIC_STEPS+1];
    logic            v_ready [CORDIC_STEPS+1];
    t_vec            v_data  [CORDIC_STEPS+1];
    logic [AngW-1:0] s_left, s_right, s_larger;

    awa_entry u_entry (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_radius    (i_s_axis_tdata),
        .i_dir       (i_s_axis_tuser),
        .o_valid     (v_valid[0]),
        .i_ready     (v_ready[0]),
        .o_data      (v_data[0])
    );

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        awa_cell #(.STEP(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v_valid[g]),
            .o_ready (v_ready[g]),
            .i_data  (v_data[g]),
            .o_valid (v_valid[g+1]),
            .i_ready (v_ready[g+1]),
            .o_data  (v_data[g+1])
        );
    end

    awa_finish u_finish (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (v_valid[CORDIC_STEPS]),
        .o_ready  (v_ready[CORDIC_STEPS]),
        .i_data   (v_data[CORDIC_STEPS]),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_left   (s_left),
        .o_right  (s_right),
        .o_larger (s_larger)
    );

    assign o_m_axis_tdata = {s_larger, s_right, s_left};
endmodule

// File: rtl/awa_check.sv
// Port-level checks of the wheel-angle unit, bound to the top level.
module awa_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata
);
    import awa_pkg::*;

    localparam logic [AngW-1:0] MaxAng = 16'd46080;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output word valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled output word changed");

    a_larger: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[47:32] ==
            ((o_m_axis_tdata[15:0] > o_m_axis_tdata[31:16]) ?
             o_m_axis_tdata[15:0] : o_m_axis_tdata[31:16]))
        else $error("larger angle is not the maximum");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[15:0] <= MaxAng && o_m_axis_tdata[31:16] <= MaxAng)
        else $error("wheel angle beyond 180 degrees");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled while output is empty");
endmodule

bind ackermann_wheel_angles awa_check u_awa_check (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

// File: tb/ackermann_wheel_angles_tb.sv
// Self-checking testbench for the Ackermann wheel-angle unit: stream stimulus and CORDIC predictor.
module ackermann_wheel_angles_tb;

    localparam int unsigned Steps    = awa_pkg::DefSteps;
    localparam int unsigned DrainPad = Steps + 3 + 4;
    localparam int unsigned CycleCap = 400000;
    localparam int unsigned NumRand  = 1150;
    localparam int unsigned NumTail  = 150;
    localparam longint      Deg90    = 64'sd5898240;
    localparam longint      Deg180   = 64'sd11796480;

    // packed from the top bit down, so left sits in [15:0] like the output word
    typedef struct packed {
        logic [15:0] larger;
        logic [15:0] right;
        logic [15:0] left;
    } t_wheel_angles;

    typedef struct {
        t_wheel_angles angles;
        logic [15:0]   radius;
        logic          heading;
    } t_pending_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [awa_pkg::CfgIdxW-1:0] i_cfg_index = awa_pkg::RegTrackWidth;
    logic [awa_pkg::LenW-1:0]    i_cfg_data = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata = '0;
    logic        i_s_axis_tuser = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [47:0] o_m_axis_tdata;

    // atan(2^-k) in degrees, Q.16
    longint atan_q16 [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304,
        58666,   29335,   14668,  7334,   3667,   1833,
        917,     458,     229,    115,    57,     29,
        14,      7,       4,      2,      1,      0
    };

    logic [15:0] cur_track = awa_pkg::TrackReset;
    logic [15:0] cur_base  = awa_pkg::BaseReset;

    t_pending_word pending_angles [$];
    int unsigned   err_count = 0;
    int unsigned   words_sent = 0;
    int unsigned   words_checked = 0;
    int unsigned   geometry_count = 0;
    int unsigned   drain_pauses = 0;
    int unsigned   cycle_count = 0;
    int unsigned   stall_left = 0;
    bit            gap_en = 1'b0;
    bit            stall_en = 1'b0;

    ackermann_wheel_angles #(
        .CORDIC_STEPS(Steps)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Vectoring CORDIC on (2L, num), then 90 -/+ z, clamp and round to Q8.8.
    function automatic logic [15:0] wheel_deg(input longint num, input bit fwd,
                                              input longint base);
        longint x, y, z, xs, ys, acc;
        int k;
        x = 2 * base * 256;
        y = num * 256;
        z = 0;
        for (k = 0; k < Steps && k < 24; k++) begin
            xs = x >>> k;
            ys = y >>> k;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + atan_q16[k];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - atan_q16[k];
            end
        end
        acc = fwd ? Deg90 - z : Deg90 + z;
        if (acc < 0) acc = 0;
        if (acc > Deg180) acc = Deg180;
        return 16'((acc + 128) >>> 8);
    endfunction

    function automatic t_wheel_angles steer_angles(input logic [15:0] radius,
                                                   input logic heading);
        t_wheel_angles res;
        longint r2;
        r2 = 2 * longint'(radius);
        res.left   = wheel_deg(r2 + longint'(cur_track), heading, longint'(cur_base));
        res.right  = wheel_deg(r2 - longint'(cur_track), heading, longint'(cur_base));
        res.larger = (res.left > res.right) ? res.left : res.right;
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= 20) $display("mismatch: %s", what);
    endtask

    // Hold the source quiet until every expected word has come back, then let the pipe settle.
    task automatic hold_until_drained(input int unsigned pad);
        i_s_axis_tvalid <= 1'b0;
        while (pending_angles.size() != 0) @(posedge i_clk);
        repeat (pad) @(posedge i_clk);
    endtask

    // Write both registers back to back; only called while the block is idle.
    task automatic set_geometry(input logic [15:0] track, input logic [15:0] base);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= awa_pkg::RegTrackWidth;
        i_cfg_data  <= track;
        do @(posedge i_clk); while (!o_cfg_ready);
        cur_track = track;
        i_cfg_index <= awa_pkg::RegWheelbase;
        i_cfg_data  <= base;
        do @(posedge i_clk); while (!o_cfg_ready);
        cur_base = base;
        i_cfg_valid <= 1'b0;
        geometry_count++;
        @(posedge i_clk);
    endtask

    task automatic send_word(input logic [15:0] radius, input logic heading);
        t_pending_word pw;
        if (gap_en && $urandom_range(0, 5) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= radius;
        i_s_axis_tuser  <= heading;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pw.angles  = steer_angles(radius, heading);
        pw.radius  = radius;
        pw.heading = heading;
        pending_angles.push_back(pw);
        words_sent++;
    endtask

    function automatic logic [15:0] pick_radius(input logic [15:0] track);
        int r;
        case ($urandom_range(0, 3))
            0: begin
                // land near the inner wheel's zero crossing
                r = int'(track / 2) + $urandom_range(0, 8) - 4;
                if (r < 0) r = 0;
                if (r > 65535) r = 65535;
            end
            1: r = $urandom_range(0, 4095);
            default: r = $urandom_range(0, 65535);
        endcase
        return 16'(r);
    endfunction

    function automatic logic [15:0] pick_base();
        case ($urandom_range(0, 4))
            0: return 16'd1;
            1: return 16'd65535;
            2: return 16'($urandom_range(1, 4096));
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else if (stall_en && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 15) - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_pending_word pw;
        t_wheel_angles got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata;
            if (pending_angles.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h", o_m_axis_tdata));
            end else begin
                pw = pending_angles.pop_front();
                words_checked++;
                if (got.left != pw.angles.left)
                    report_mismatch($sformatf("R=%0d h=%0d left %0d, want %0d",
                        pw.radius, pw.heading, got.left, pw.angles.left));
                if (got.right != pw.angles.right)
                    report_mismatch($sformatf("R=%0d h=%0d right %0d, want %0d",
                        pw.radius, pw.heading, got.right, pw.angles.right));
                if (got.larger != pw.angles.larger)
                    report_mismatch($sformatf("R=%0d h=%0d larger %0d, want %0d",
                        pw.radius, pw.heading, got.larger, pw.angles.larger));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleCap) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Reset geometry: zero track, wheelbase 16.
    task automatic test_reset_geometry();
        send_word(16'd0, 1'b1);
        send_word(16'd0, 1'b0);
        send_word(16'd65535, 1'b1);
        send_word(16'd65535, 1'b0);
        send_word(16'd8, 1'b1);
        hold_until_drained(DrainPad);
    endtask

    // Extreme geometries, negative and zero numerators, zero wheelbase.
    task automatic test_directed_cases();
        set_geometry(16'd65535, 16'd65535);
        send_word(16'd0, 1'b1);
        send_word(16'd0, 1'b0);
        send_word(16'd32767, 1'b1);
        send_word(16'd32768, 1'b0);
        send_word(16'd65535, 1'b1);
        hold_until_drained(DrainPad);
        set_geometry(16'd0, 16'd1);
        send_word(16'd0, 1'b1);
        send_word(16'd1, 1'b0);
        send_word(16'd65535, 1'b1);
        send_word(16'd65535, 1'b0);
        hold_until_drained(DrainPad);
        set_geometry(16'd0, 16'd0);
        send_word(16'd0, 1'b1);
        send_word(16'd0, 1'b0);
        send_word(16'd100, 1'b1);
        send_word(16'd100, 1'b0);
        hold_until_drained(DrainPad);
        set_geometry(16'd200, 16'd0);
        send_word(16'd100, 1'b1);
        send_word(16'd100, 1'b0);
        hold_until_drained(DrainPad);
    endtask

    // Random words over many geometries with idling on both sides.
    task automatic test_random_geometry();
        int unsigned done_words;
        int unsigned phase_len;
        logic [15:0] track;
        done_words = 0;
        while (done_words < NumRand) begin
            track = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 1023))
                                                : 16'($urandom_range(0, 65535));
            set_geometry(track, pick_base());
            gap_en   = ($urandom_range(0, 4) != 0);
            stall_en = ($urandom_range(0, 4) != 0);
            phase_len = $urandom_range(40, 120);
            repeat (phase_len) begin
                send_word(pick_radius(cur_track), 1'($urandom_range(0, 1)));
                done_words++;
                if ($urandom_range(0, 39) == 0) begin
                    hold_until_drained(0);
                    drain_pauses++;
                end
            end
            hold_until_drained(DrainPad);
        end
    endtask

    // Back-to-back words with no idling anywhere.
    task automatic test_streaming_tail();
        gap_en   = 1'b0;
        stall_en = 1'b0;
        set_geometry(16'($urandom_range(0, 65535)), pick_base());
        repeat (NumTail) send_word(pick_radius(cur_track), 1'($urandom_range(0, 1)));
        hold_until_drained(DrainPad);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_geometry();
        test_directed_cases();
        test_random_geometry();
        test_streaming_tail();
        if (pending_angles.size() != 0)
            report_mismatch($sformatf("%0d words never came back", pending_angles.size()));
        $display("covered %0d steering words (%0d checked) over %0d geometry settings,",
                 words_sent, words_checked, geometry_count);
        $display("with %0d mid-phase drain pauses and %0d mismatches", drain_pauses, err_count);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
